### src/alarm_timer_queue_core_macros.svh
// Assertion macros used by the alarm timer queue checker.
`ifndef ALARM_TIMER_QUEUE_CORE_MACROS_SVH
`define ALARM_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/atq_pkg.sv
// Types and constants of the alarm timer queue.
package atq_pkg;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ARM    = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        EV_FIRED     = 3'd0,
        EV_ARMED     = 3'd1,
        EV_FULL      = 3'd2,
        EV_CANCELLED = 3'd3,
        EV_NOT_FOUND = 3'd4
    } event_t;

    localparam int OWNER_W = 8;
    localparam int DUR_W   = 32;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] MAX_FIRES   = 5'd16;
    localparam logic [31:0]      REARM_RESET = 32'd3000000;

endpackage

### src/atq_alu.sv
// Shared time adder and wrap-around time comparator.
module atq_alu #(
    parameter int TIME_BITS = 40
) (
    input  logic [TIME_BITS-1:0] add_a,
    input  logic [TIME_BITS-1:0] add_b,
    output logic [TIME_BITS-1:0] sum,
    input  logic [TIME_BITS-1:0] cmp_a,
    input  logic [TIME_BITS-1:0] cmp_b,
    output logic                 earlier
);

    logic [TIME_BITS-1:0] diff;

    assign sum     = add_a + add_b;
    assign diff    = cmp_a - cmp_b;
    // cmp_a is earlier than cmp_b when the wrapped difference is negative
    assign earlier = diff[TIME_BITS-1];

endmodule

### src/alarm_timer_queue_core.sv
// Alarm timer queue: slot table, time counter and scan sequencer.
// Tick: scans the table to find due slots, then fires each marked slot in turn, skipping the rest.
// Arm: one table scan. Cancel: two table scans if found, one if not.
// One transaction at a time; the slot scan through the table sets the rate.
// Results leave through an output register, so the next item is taken while one waits.
// Synchronous active-low reset clears time, empties the table, rearm interval 3000000.
module alarm_timer_queue_core
    import atq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] owner, [39:8] duration
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] target_owner, [8] earliest_changed, [15:9] zero
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = $clog2(DEPTH + 1);
    localparam int PW = TIME_BITS - DUR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FCHK,
        ST_FUPD,
        ST_RESP
    } state_t;

    state_t               state_reg;
    kind_t                kind_reg;
    logic [IW-1:0]        idx_reg;
    logic                 ev_vld_reg;
    logic [AW-1:0]        ev_idx_reg;
    logic                 phase_reg;
    logic                 found_reg;
    logic                 flag_reg;
    logic [AW-1:0]        sel_reg;
    logic [OWNER_W-1:0]   owner_reg;
    logic [TIME_BITS-1:0] key_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [31:0]          rearm_reg;
    logic [DEPTH-1:0]     valid_reg;
    logic [DEPTH-1:0]     mask_reg;
    logic [CNT_W-1:0]     fcnt_reg;
    logic                 m_tvalid_reg;
    event_t               m_ev_reg;
    logic [OWNER_W-1:0]   m_owner_reg;
    logic                 m_chg_reg;
    logic                 m_last_reg;

    logic [TIME_BITS-1:0] exp_mem [DEPTH];
    logic [OWNER_W-1:0]   own_mem [DEPTH];
    logic [TIME_BITS-1:0] rd_exp_reg;
    logic [OWNER_W-1:0]   rd_own_reg;

    logic [AW-1:0]        rd_addr;
    logic [TIME_BITS-1:0] add_a;
    logic [TIME_BITS-1:0] add_b;
    logic [TIME_BITS-1:0] sum;
    logic [TIME_BITS-1:0] cmp_a;
    logic [TIME_BITS-1:0] cmp_b;
    logic                 lt;
    logic                 ev_valid;
    logic                 ev_last;
    logic                 out_free;
    logic                 res_load;
    logic                 tick_hit;
    logic                 cancel_hit;
    logic                 fire_last;
    logic                 mem_we;
    logic                 own_we;
    logic [AW-1:0]        wr_addr;
    logic [TIME_BITS-1:0] wr_exp;

    atq_alu #(
        .TIME_BITS(TIME_BITS)
    ) u_atq_alu (
        .add_a  (add_a),
        .add_b  (add_b),
        .sum    (sum),
        .cmp_a  (cmp_a),
        .cmp_b  (cmp_b),
        .earlier(lt)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_ev_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {7'b0, m_chg_reg, m_owner_reg};

    assign rd_addr    = (idx_reg < IW'(DEPTH)) ? idx_reg[AW-1:0] : '0;
    assign ev_valid   = valid_reg[ev_idx_reg];
    assign ev_last    = (ev_idx_reg == AW'(DEPTH - 1));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign res_load   = out_free && (state_reg == ST_FUPD || state_reg == ST_RESP);
    assign tick_hit   = ev_valid && !lt && (fcnt_reg < MAX_FIRES);
    assign cancel_hit = ev_valid && (rd_own_reg == owner_reg) && (!found_reg || lt);
    assign fire_last  = ((mask_reg & ~(DEPTH'(1) << rd_addr)) == '0);

    always_comb begin
        if (state_reg == ST_FUPD) begin
            add_a = rd_exp_reg;
            add_b = {{PW{1'b0}}, rearm_reg};
        end else begin
            add_a = now_reg;
            add_b = (s_tuser == KIND_TICK) ? TIME_BITS'(1)
                                           : {{PW{1'b0}}, s_tdata[39:8]};
        end
    end

    always_comb begin
        case (kind_reg)
            KIND_TICK: begin
                cmp_a = now_reg;
                cmp_b = rd_exp_reg;
            end
            KIND_CANCEL: begin
                cmp_a = phase_reg ? key_reg : rd_exp_reg;
                cmp_b = phase_reg ? rd_exp_reg : key_reg;
            end
            default: begin
                cmp_a = key_reg;
                cmp_b = rd_exp_reg;
            end
        endcase
    end

    always_comb begin
        mem_we  = 1'b0;
        own_we  = 1'b0;
        wr_addr = rd_addr;
        wr_exp  = sum;
        if (state_reg == ST_FUPD && out_free) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_RESP && out_free && kind_reg == KIND_ARM && found_reg) begin
            mem_we  = 1'b1;
            own_we  = 1'b1;
            wr_addr = sel_reg;
            wr_exp  = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            exp_mem[wr_addr] <= wr_exp;
        end
        if (own_we) begin
            own_mem[wr_addr] <= owner_reg;
        end
        rd_exp_reg <= exp_mem[rd_addr];
        rd_own_reg <= own_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_NONE;
            idx_reg      <= '0;
            ev_vld_reg   <= 1'b0;
            phase_reg    <= 1'b0;
            found_reg    <= 1'b0;
            flag_reg     <= 1'b0;
            now_reg      <= '0;
            rearm_reg    <= REARM_RESET;
            valid_reg    <= '0;
            mask_reg     <= '0;
            fcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !res_load) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                rearm_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    ev_vld_reg <= 1'b0;
                    if (s_tvalid) begin
                        kind_reg  <= kind_t'(s_tuser);
                        owner_reg <= s_tdata[7:0];
                        key_reg   <= sum;
                        idx_reg   <= '0;
                        phase_reg <= 1'b0;
                        found_reg <= 1'b0;
                        flag_reg  <= 1'b1;
                        mask_reg  <= '0;
                        fcnt_reg  <= '0;
                        if (s_tuser == KIND_TICK) begin
                            now_reg <= sum;
                        end
                        if (s_tuser != KIND_NONE) begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (idx_reg < IW'(DEPTH)) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                    ev_vld_reg <= (idx_reg < IW'(DEPTH));
                    ev_idx_reg <= rd_addr;
                    if (ev_vld_reg) begin
                        case (kind_reg)
                            KIND_TICK: begin
                                if (tick_hit) begin
                                    mask_reg[ev_idx_reg] <= 1'b1;
                                    fcnt_reg             <= fcnt_reg + CNT_W'(1);
                                end
                            end
                            KIND_ARM: begin
                                if (ev_valid && !lt) begin
                                    flag_reg <= 1'b0;
                                end
                                if (!ev_valid && !found_reg) begin
                                    found_reg <= 1'b1;
                                    sel_reg   <= ev_idx_reg;
                                end
                            end
                            KIND_CANCEL: begin
                                if (!phase_reg) begin
                                    if (cancel_hit) begin
                                        found_reg <= 1'b1;
                                        sel_reg   <= ev_idx_reg;
                                        key_reg   <= rd_exp_reg;
                                    end
                                end else if (ev_idx_reg != sel_reg && ev_valid && !lt) begin
                                    flag_reg <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                        if (ev_last) begin
                            case (kind_reg)
                                KIND_TICK: begin
                                    idx_reg   <= '0;
                                    state_reg <= (mask_reg != '0 || tick_hit) ? ST_FCHK
                                                                              : ST_IDLE;
                                end
                                KIND_CANCEL: begin
                                    if (!phase_reg && (found_reg || cancel_hit)) begin
                                        phase_reg <= 1'b1;
                                        idx_reg   <= '0;
                                    end else begin
                                        state_reg <= ST_RESP;
                                    end
                                end
                                default: state_reg <= ST_RESP;
                            endcase
                        end
                    end
                end
                ST_FCHK: begin
                    if (idx_reg >= IW'(DEPTH)) begin
                        state_reg <= ST_IDLE;
                    end else if (mask_reg[rd_addr]) begin
                        state_reg <= ST_FUPD;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                ST_FUPD: begin
                    if (out_free) begin
                        m_tvalid_reg      <= 1'b1;
                        m_ev_reg          <= EV_FIRED;
                        m_owner_reg       <= rd_own_reg;
                        m_chg_reg         <= 1'b0;
                        m_last_reg        <= fire_last;
                        mask_reg[rd_addr] <= 1'b0;
                        idx_reg           <= idx_reg + IW'(1);
                        state_reg         <= fire_last ? ST_IDLE : ST_FCHK;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_owner_reg  <= owner_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                        if (kind_reg == KIND_ARM) begin
                            m_ev_reg  <= found_reg ? EV_ARMED : EV_FULL;
                            m_chg_reg <= found_reg && flag_reg;
                            if (found_reg) begin
                                valid_reg[sel_reg] <= 1'b1;
                            end
                        end else begin
                            m_ev_reg  <= found_reg ? EV_CANCELLED : EV_NOT_FOUND;
                            m_chg_reg <= found_reg && flag_reg;
                            if (found_reg) begin
                                valid_reg[sel_reg] <= 1'b0;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/atq_checker.sv
// Port-level checker for the alarm timer queue, bound to the top level.
`include "alarm_timer_queue_core_macros.svh"

module atq_checker
    import atq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    `ATQ_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ATQ_ASSERT_NOW(a_single_last, m_tvalid && m_tuser != EV_FIRED, m_tlast, "single result not last")
    `ATQ_ASSERT_NOW(a_fire_nowake, m_tvalid && m_tuser == EV_FIRED, !m_tdata[8], "fire with wake flag")
    `ATQ_ASSERT_NEXT(a_busy, s_tvalid && s_tready && (s_tuser == KIND_ARM || s_tuser == KIND_CANCEL), !s_tready, "ready during table scan")

endmodule

bind alarm_timer_queue_core atq_checker u_atq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
